// ===== rtl/core/ggs_pkg.sv =====
// Shared types, constants and helpers for the geometric gap sampler.
`default_nettype none
package ggs_pkg;

    localparam int DEF_GAP_WIDTH     = 21;
    localparam int DEF_LOG_FRAC_BITS = 26;

    localparam logic [14:0] LCG_MUL      = 15'd16807;
    localparam logic [30:0] LCG_MOD      = 31'h7FFF_FFFF;
    localparam logic [30:0] SEED_DEFAULT = 31'd35749;
    localparam logic [15:0] MEAN_DEFAULT = 16'd100;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_IDX_W-1:0] REG_SEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LG_LOAD,
        ST_LG_NORM,
        ST_LG_SQ,
        ST_LG_END,
        ST_LCG_MUL,
        ST_LCG_FOLD,
        ST_DIV,
        ST_EVAL
    } state_t;

    typedef enum logic [1:0] {
        SEL_MEAN,
        SEL_MEAN1,
        SEL_X
    } log_sel_t;

    typedef struct packed {
        logic     ld_log;
        logic     norm;
        logic     sq;
        logic     commit;
        logic     lcg_mul;
        logic     lcg_fold;
        logic     div_step;
        logic     out_ld;
        log_sel_t sel;
    } cmd_t;

    typedef struct packed {
        logic y_top;
        logic sq_last;
        logic div_last;
        logic mean_small;
        logic denom_zero;
        logic reject;
    } sts_t;

    // Fixed log2 of the generator modulus, evaluated at elaboration
    function automatic logic [63:0] log_mod_fixed(input int frac_bits);
        logic [63:0] y;
        logic [63:0] frac;
        int i;
        y = {33'd0, LCG_MOD} << 1;
        frac = 64'd0;
        for (i = 0; i < frac_bits; i++)
        begin
            y = (y * y) >> 31;
            frac = frac << 1;
            if (y >= (64'd1 << 32))
            begin
                y = y >> 1;
                frac = frac | 64'd1;
            end
        end
        return (64'd30 << frac_bits) | frac;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/geometric_gap_sampler_top.sv =====
// Top level of the geometric gap sampler.
//
//  channel  direction  handshake              payload
//  cfg      in         cfg_we                 cfg_index, cfg_data
//  in       in         in_valid / in_ready    draw_request
//  out      out        out_valid / out_ready  gap_length, saturated
//
// A draw runs up to three logs, the generator multiply and fold, the restoring
// divider and an accept and a result step.
// Each redraw repeats one log, the generator and the divider. The log uses a single
// shared squaring multiplier; the divider makes one quotient bit per cycle.
// Reset loads seed 35749 and mean 100; no clearing pass. A beat of draw 0 is
// taken and dropped. The finished result waits in the output register.
`default_nettype none
module geometric_gap_sampler_top #(
    parameter int GAP_WIDTH     = ggs_pkg::DEF_GAP_WIDTH,
    parameter int LOG_FRAC_BITS = ggs_pkg::DEF_LOG_FRAC_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [ggs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ggs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            draw_request,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [GAP_WIDTH-1:0]                 gap_length,
    output logic                                 saturated
);
    import ggs_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ggs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .draw_request (draw_request),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    ggs_datapath #(
        .GAP_WIDTH     (GAP_WIDTH),
        .LOG_FRAC_BITS (LOG_FRAC_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .sts        (sts),
        .gap_length (gap_length),
        .saturated  (saturated)
    );

endmodule
`default_nettype wire

// ===== rtl/core/ggs_ctrl.sv =====
// Sequencer for the sampler: log, generator, divide and output steps.
`default_nettype none
module ggs_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          draw_request,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire ggs_pkg::sts_t sts,
    output ggs_pkg::cmd_t      cmd
);
    import ggs_pkg::*;

    state_t   state_reg, state_next;
    log_sel_t sel_reg, sel_next;
    logic     out_valid_reg, out_valid_next;
    logic     out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= SEL_MEAN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && draw_request)
                begin
                    sel_next   = SEL_MEAN;
                    state_next = sts.mean_small ? ST_LCG_MUL : ST_LG_LOAD;
                end
            end
            ST_LG_LOAD: state_next = ST_LG_NORM;
            ST_LG_NORM:
            begin
                if (sts.y_top)
                    state_next = ST_LG_SQ;
            end
            ST_LG_SQ:
            begin
                if (sts.sq_last)
                    state_next = ST_LG_END;
            end
            ST_LG_END:
            begin
                unique case (sel_reg)
                    SEL_MEAN:
                    begin
                        sel_next   = SEL_MEAN1;
                        state_next = ST_LG_LOAD;
                    end
                    SEL_MEAN1: state_next = ST_LCG_MUL;
                    default:   state_next = ST_DIV;
                endcase
            end
            ST_LCG_MUL: state_next = ST_LCG_FOLD;
            ST_LCG_FOLD:
            begin
                if (sts.mean_small || sts.denom_zero)
                    state_next = ST_EVAL;
                else
                begin
                    sel_next   = SEL_X;
                    state_next = ST_LG_LOAD;
                end
            end
            ST_DIV:
            begin
                if (sts.div_last)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (sts.reject)
                    state_next = ST_LCG_MUL;
                else if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.sel      = sel_reg;
        cmd.ld_log   = (state_reg == ST_LG_LOAD);
        cmd.norm     = (state_reg == ST_LG_NORM) && !sts.y_top;
        cmd.sq       = (state_reg == ST_LG_SQ);
        cmd.commit   = (state_reg == ST_LG_END);
        cmd.lcg_mul  = (state_reg == ST_LCG_MUL);
        cmd.lcg_fold = (state_reg == ST_LCG_FOLD);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.out_ld   = (state_reg == ST_EVAL) && !sts.reject && out_free;

        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (cmd.out_ld)
            out_valid_next = 1'b1;
    end

endmodule
`default_nettype wire

// ===== rtl/core/ggs_datapath.sv =====
// Generator, iterative fixed-point log, restoring divider and result register.
`default_nettype none
module ggs_datapath #(
    parameter int GAP_WIDTH     = ggs_pkg::DEF_GAP_WIDTH,
    parameter int LOG_FRAC_BITS = ggs_pkg::DEF_LOG_FRAC_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [ggs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ggs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire ggs_pkg::cmd_t                   cmd,
    output ggs_pkg::sts_t                        sts,
    output logic [GAP_WIDTH-1:0]                 gap_length,
    output logic                                 saturated
);
    import ggs_pkg::*;

    localparam int QW   = LOG_FRAC_BITS + 5;
    localparam int CW   = $clog2(QW);
    localparam int CMPW = (QW > GAP_WIDTH + 1) ? QW : GAP_WIDTH + 1;
    localparam logic [QW-1:0]        LOG_M   = QW'(log_mod_fixed(LOG_FRAC_BITS));
    localparam logic [GAP_WIDTH-1:0] GAP_MAX = {GAP_WIDTH{1'b1}};

    logic [30:0]              x_reg;
    logic [15:0]              mean_reg;
    logic [GAP_WIDTH:0]       last_reg;
    logic [45:0]              prod_reg;
    logic [31:0]              y_reg;
    logic [4:0]               e_reg;
    logic [LOG_FRAC_BITS-1:0] frac_reg;
    logic [CW-1:0]            cnt_reg;
    logic [QW-1:0]            lm_reg, denom_reg, q_reg, rem_reg;
    logic [GAP_WIDTH-1:0]     gap_reg;
    logic                     sat_reg;

    logic [30:0]          seed_safe, log_opd;
    logic [31:0]          fold_sum;
    logic [30:0]          fold_res;
    logic [63:0]          sq_full;
    logic [32:0]          sq_t;
    logic [QW-1:0]        log_val, num_c;
    logic [QW:0]          div_tr;
    logic                 div_ge;
    logic [CMPW-1:0]      q_ext;
    logic                 q_big;
    logic [GAP_WIDTH-1:0] gap_c;
    logic                 sat_c;

    // Seeds that would lock the generator fall back to the default
    always_comb
    begin
        seed_safe = cfg_data[30:0];
        if (seed_safe == 31'd0 || seed_safe == LCG_MOD)
            seed_safe = SEED_DEFAULT;
    end

    // Mersenne fold: hi + lo, one conditional subtract
    assign fold_sum = {1'b0, prod_reg[30:0]} + {17'd0, prod_reg[45:31]};
    assign fold_res = (fold_sum >= {1'b0, LCG_MOD}) ? 31'(fold_sum - {1'b0, LCG_MOD})
                                                     : fold_sum[30:0];

    always_comb
    begin
        case (cmd.sel)
            SEL_MEAN:  log_opd = {15'd0, mean_reg};
            SEL_MEAN1: log_opd = {15'd0, 16'(mean_reg - 16'd1)};
            default:   log_opd = x_reg;
        endcase
        if (log_opd == 31'd0)
            log_opd = 31'd1;
    end

    assign sq_full = y_reg * y_reg;
    assign sq_t    = sq_full[63:31];
    assign log_val = {e_reg, frac_reg};
    assign num_c   = (LOG_M > log_val) ? QW'(LOG_M - log_val) : '0;

    assign div_tr = {rem_reg, q_reg[QW-1]};
    assign div_ge = (div_tr >= {1'b0, denom_reg});

    assign q_ext = CMPW'(q_reg);
    assign q_big = (q_ext >= CMPW'(GAP_MAX));

    always_comb
    begin
        sat_c = 1'b0;
        if (sts.mean_small)
            gap_c = GAP_WIDTH'(1);
        else if (sts.denom_zero || q_big)
        begin
            gap_c = GAP_MAX;
            sat_c = 1'b1;
        end
        else
            gap_c = GAP_WIDTH'(q_ext + CMPW'(1));
    end

    assign sts.y_top      = y_reg[31];
    assign sts.sq_last    = (cnt_reg == CW'(LOG_FRAC_BITS - 1));
    assign sts.div_last   = (cnt_reg == CW'(QW - 1));
    assign sts.mean_small = (mean_reg < 16'd2);
    assign sts.denom_zero = (denom_reg == '0);
    assign sts.reject     = ({1'b0, gap_c} == last_reg);

    assign gap_length = gap_reg;
    assign saturated  = sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= SEED_DEFAULT;
            mean_reg <= MEAN_DEFAULT;
            last_reg <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_SEED)
                x_reg <= seed_safe;
            else if (cmd.lcg_fold)
                x_reg <= fold_res;
            if (cfg_we && cfg_index == REG_MEAN)
                mean_reg <= cfg_data[15:0];
            if (cmd.out_ld)
                last_reg <= {1'b0, gap_c} + (GAP_WIDTH+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lcg_mul)
            prod_reg <= x_reg * LCG_MUL;

        if (cmd.ld_log)
        begin
            y_reg   <= {1'b0, log_opd};
            e_reg   <= 5'd31;
            cnt_reg <= '0;
        end
        else if (cmd.norm)
        begin
            y_reg <= {y_reg[30:0], 1'b0};
            e_reg <= e_reg - 5'd1;
        end
        else if (cmd.sq)
        begin
            y_reg    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
            frac_reg <= {frac_reg[LOG_FRAC_BITS-2:0], sq_t[32]};
            cnt_reg  <= cnt_reg + CW'(1);
        end
        else if (cmd.commit)
        begin
            cnt_reg <= '0;
            case (cmd.sel)
                SEL_MEAN:  lm_reg    <= log_val;
                SEL_MEAN1: denom_reg <= QW'(lm_reg - log_val);
                default:
                begin
                    q_reg   <= num_c;
                    rem_reg <= '0;
                end
            endcase
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_ge ? QW'(div_tr - {1'b0, denom_reg}) : div_tr[QW-1:0];
            q_reg   <= {q_reg[QW-2:0], div_ge};
            cnt_reg <= cnt_reg + CW'(1);
        end

        if (cmd.out_ld)
        begin
            gap_reg <= gap_c;
            sat_reg <= sat_c;
        end
    end

endmodule
`default_nettype wire
